@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the 6502 address mode unit RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check, off while reset is asserted (active-low reset)
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ hdl/cau_pkg.sv @@
// ---------------------------------------------------------------------------
// cau_pkg
// Types, opcode constants and payload layout for the 6502 address mode unit.
// ---------------------------------------------------------------------------
package cau_pkg;

    localparam int ByteW  = 8;
    localparam int AddrW  = 16;
    localparam int ModeW  = 4;
    localparam int KindW  = 2;

    // Stream payload widths (whole bytes)
    localparam int InDataW  = 72;
    localparam int OutDataW = 72;

    // Opcodes with their own decode rules
    localparam logic [ByteW-1:0] OP_JSR       = 8'h20;
    localparam logic [ByteW-1:0] OP_JMP_IND   = 8'h6C;
    localparam logic [ByteW-1:0] OP_STX_ZPY   = 8'h96;
    localparam logic [ByteW-1:0] OP_LDX_ZPY   = 8'hB6;
    localparam logic [ByteW-1:0] OP_LDX_ABSY  = 8'hBE;
    localparam logic [ByteW-1:0] OP_IMP_SPLIT = 8'h7A;

    // Opcode group (cc field)
    localparam logic [1:0] CC_GROUP0 = 2'd0;
    localparam logic [1:0] CC_GROUP1 = 2'd1;
    localparam logic [1:0] CC_GROUP2 = 2'd2;

    typedef enum logic [ModeW-1:0] {
        MODE_IMP  = 4'd0,
        MODE_ACC  = 4'd1,
        MODE_IMM  = 4'd2,
        MODE_ZP   = 4'd3,
        MODE_ZPX  = 4'd4,
        MODE_ZPY  = 4'd5,
        MODE_ABS  = 4'd6,
        MODE_ABSX = 4'd7,
        MODE_ABSY = 4'd8,
        MODE_IND  = 4'd9,
        MODE_XIND = 4'd10,
        MODE_INDY = 4'd11,
        MODE_REL  = 4'd12,
        MODE_UND  = 4'd13
    } mode_t;

    typedef enum logic [KindW-1:0] {
        KIND_FINAL  = 2'd0,
        KIND_REQ    = 2'd1,
        KIND_IGNORE = 2'd2
    } kind_t;

    // Action carried in the input tuser
    localparam logic ACT_INSTR = 1'b0;
    localparam logic ACT_REPLY = 1'b1;

    typedef struct packed {
        logic              action;
        logic [ByteW-1:0]  opcode;
        logic [AddrW-1:0]  pc;
        logic [ByteW-1:0]  reg_x;
        logic [ByteW-1:0]  reg_y;
        logic [ByteW-1:0]  operand_lo;
        logic [ByteW-1:0]  operand_hi;
        logic [ByteW-1:0]  pointer_lo;
        logic [ByteW-1:0]  pointer_hi;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        mode_t             mode;
        logic [AddrW-1:0]  eff_addr;
        logic [AddrW-1:0]  next_pc;
        logic [AddrW-1:0]  read_addr_lo;
        logic [AddrW-1:0]  read_addr_hi;
    } result_t;

endpackage

@@ hdl/cau_decode.sv @@
// ---------------------------------------------------------------------------
// cau_decode
// Opcode to addressing mode decode from the aaabbbcc fields.
// ---------------------------------------------------------------------------
module cau_decode
    import cau_pkg::*;
(
    input  logic [ByteW-1:0] opcode,
    output mode_t            mode
);

    logic [1:0] cc;
    logic [2:0] bbb;

    assign cc  = opcode[1:0];
    assign bbb = opcode[4:2];

    // Map group and bbb field to a mode
    always_comb begin
        mode = MODE_UND;
        case (cc)
            CC_GROUP1: begin
                case (bbb)
                    3'd0:    mode = MODE_XIND;
                    3'd1:    mode = MODE_ZP;
                    3'd2:    mode = MODE_IMM;
                    3'd3:    mode = MODE_ABS;
                    3'd4:    mode = MODE_INDY;
                    3'd5:    mode = MODE_ZPX;
                    3'd6:    mode = MODE_ABSY;
                    default: mode = MODE_ABSX;
                endcase
            end
            CC_GROUP2: begin
                case (bbb)
                    3'd0:       mode = MODE_IMM;
                    3'd1:       mode = MODE_ZP;
                    3'd2, 3'd6: mode = (opcode > OP_IMP_SPLIT) ? MODE_IMP : MODE_ACC;
                    3'd3:       mode = MODE_ABS;
                    3'd5: begin
                        mode = (opcode == OP_LDX_ZPY || opcode == OP_STX_ZPY)
                               ? MODE_ZPY : MODE_ZPX;
                    end
                    3'd7:       mode = (opcode == OP_LDX_ABSY) ? MODE_ABSY : MODE_ABSX;
                    default:    mode = MODE_UND;
                endcase
            end
            CC_GROUP0: begin
                if (opcode == OP_JSR) begin
                    mode = MODE_ABS;
                end else if (opcode == OP_JMP_IND) begin
                    mode = MODE_IND;
                end else begin
                    case (bbb)
                        3'd0:       mode = MODE_IMM;
                        3'd1:       mode = MODE_ZP;
                        3'd2, 3'd6: mode = MODE_IMP;
                        3'd3:       mode = MODE_ABS;
                        3'd4:       mode = MODE_REL;
                        3'd5:       mode = MODE_ZPX;
                        default:    mode = MODE_ABSX;
                    endcase
                end
            end
            default: mode = MODE_UND;
        endcase
    end

endmodule

@@ hdl/cau_exec.sv @@
// ---------------------------------------------------------------------------
// cau_exec
// Address formation and pending pointer-fetch state for one item.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cau_exec
    import cau_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  item_t   item,
    output result_t res
);

    mode_t             dec_mode;
    logic [AddrW-1:0]  abs_val;
    logic [AddrW-1:0]  pc_inc1;
    logic [AddrW-1:0]  pc_inc2;
    logic [ByteW-1:0]  zp_x;
    logic [ByteW-1:0]  zp_y;
    logic [ByteW-1:0]  zp_x_inc;
    logic [ByteW-1:0]  zp_lo_inc;
    logic [AddrW-1:0]  rel_ofs;

    logic              pending_reg,      pending_next;
    mode_t             pending_mode_reg, pending_mode_next;
    logic [ByteW-1:0]  pending_y_reg,    pending_y_next;
    logic [AddrW-1:0]  pending_npc_reg,  pending_npc_next;

    cau_decode u_decode (
        .opcode (item.opcode),
        .mode   (dec_mode)
    );

    // Shared address terms
    assign abs_val   = {item.operand_hi, item.operand_lo};
    assign pc_inc1   = item.pc + AddrW'(1);
    assign pc_inc2   = item.pc + AddrW'(2);
    assign zp_x      = item.operand_lo + item.reg_x;
    assign zp_y      = item.operand_lo + item.reg_y;
    assign zp_x_inc  = zp_x + ByteW'(1);
    assign zp_lo_inc = item.operand_lo + ByteW'(1);
    assign rel_ofs   = {{ByteW{item.operand_lo[ByteW-1]}}, item.operand_lo};

    // Form the result and the next pending state
    always_comb begin
        res.kind         = KIND_FINAL;
        res.mode         = MODE_IMP;
        res.eff_addr     = '0;
        res.next_pc      = '0;
        res.read_addr_lo = '0;
        res.read_addr_hi = '0;

        pending_next      = pending_reg;
        pending_mode_next = pending_mode_reg;
        pending_y_next    = pending_y_reg;
        pending_npc_next  = pending_npc_reg;

        if (item.action == ACT_REPLY) begin
            if (pending_reg) begin
                res.mode     = pending_mode_reg;
                res.eff_addr = {item.pointer_hi, item.pointer_lo}
                               + {{ByteW{1'b0}}, pending_y_reg};
                res.next_pc  = pending_npc_reg;
                pending_next = 1'b0;
            end else begin
                res.kind = KIND_IGNORE;
            end
        end else begin
            pending_next = 1'b0;
            res.mode     = dec_mode;
            res.next_pc  = item.pc;
            case (dec_mode)
                MODE_IMM: begin
                    res.eff_addr = item.pc;
                    res.next_pc  = pc_inc1;
                end
                MODE_ZP: begin
                    res.eff_addr = {{ByteW{1'b0}}, item.operand_lo};
                    res.next_pc  = pc_inc1;
                end
                MODE_ZPX: begin
                    res.eff_addr = {{ByteW{1'b0}}, zp_x};
                    res.next_pc  = pc_inc1;
                end
                MODE_ZPY: begin
                    res.eff_addr = {{ByteW{1'b0}}, zp_y};
                    res.next_pc  = pc_inc1;
                end
                MODE_ABS: begin
                    res.eff_addr = abs_val;
                    res.next_pc  = pc_inc2;
                end
                MODE_ABSX: begin
                    res.eff_addr = abs_val + {{ByteW{1'b0}}, item.reg_x};
                    res.next_pc  = pc_inc2;
                end
                MODE_ABSY: begin
                    res.eff_addr = abs_val + {{ByteW{1'b0}}, item.reg_y};
                    res.next_pc  = pc_inc2;
                end
                MODE_REL: begin
                    res.eff_addr = pc_inc1 + rel_ofs;
                    res.next_pc  = pc_inc1;
                end
                MODE_IND: begin
                    // JMP indirect reads the pointer linearly
                    res.kind         = KIND_REQ;
                    res.next_pc      = pc_inc2;
                    res.read_addr_lo = abs_val;
                    res.read_addr_hi = abs_val + AddrW'(1);
                    pending_y_next   = '0;
                end
                MODE_XIND: begin
                    res.kind         = KIND_REQ;
                    res.next_pc      = pc_inc1;
                    res.read_addr_lo = {{ByteW{1'b0}}, zp_x};
                    res.read_addr_hi = {{ByteW{1'b0}}, zp_x_inc};
                    pending_y_next   = '0;
                end
                MODE_INDY: begin
                    res.kind         = KIND_REQ;
                    res.next_pc      = pc_inc1;
                    res.read_addr_lo = {{ByteW{1'b0}}, item.operand_lo};
                    res.read_addr_hi = {{ByteW{1'b0}}, zp_lo_inc};
                    pending_y_next   = item.reg_y;
                end
                default: begin
                    res.eff_addr = '0;
                end
            endcase
            if (res.kind == KIND_REQ) begin
                pending_next      = 1'b1;
                pending_mode_next = dec_mode;
                pending_npc_next  = res.next_pc;
            end
        end
    end

    // Hold the pending flag; update only when a beat moves through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
        end else if (advance) begin
            pending_reg <= pending_next;
        end
    end

    // Pending payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            pending_mode_reg <= pending_mode_next;
            pending_y_reg    <= pending_y_next;
            pending_npc_reg  <= pending_npc_next;
        end
    end

    `ASSERT_CLK(a_req_sets_pending, aclk, aresetn, (advance && res.kind == KIND_REQ) |=> pending_reg, "pointer request did not arm pending state")
    `ASSERT_CLK(a_ignore_only_idle, aclk, aresetn, (advance && res.kind == KIND_IGNORE) |-> (!pending_reg && item.action == ACT_REPLY), "reply ignored while a request was pending")
    `ASSERT_CLK(a_req_mode, aclk, aresetn, (advance && res.kind == KIND_REQ) |-> (res.mode == MODE_IND || res.mode == MODE_XIND || res.mode == MODE_INDY), "pointer request for a direct mode")
    `ASSERT_CLK(a_final_no_read, aclk, aresetn, (advance && res.kind != KIND_REQ) |-> (res.read_addr_lo == '0 && res.read_addr_hi == '0), "read address set outside a request")

endmodule

@@ hdl/cpu6502_address_mode_unit.sv @@
// ---------------------------------------------------------------------------
// cpu6502_address_mode_unit
// 6502 addressing mode decode and effective address formation.
// ---------------------------------------------------------------------------
// Usage:
//   The s_axis channel carries one beat per instruction (tuser = 0) or per
//   pointer reply (tuser = 1). An instruction beat gives opcode, pc, X, Y and
//   the operand bytes; the m_axis channel returns one beat per input beat with
//   the mode, effective address and next pc. Indirect modes return a pointer
//   read request (kind 1) with the two byte addresses; a later reply beat
//   carries the pointer bytes and produces the final result. A reply with no
//   request pending returns kind 2 with all fields zero.
//   An accepted beat passes through the input register, the decode and
//   address adders and the result register before it is valid on m_axis.
//   Throughput is one beat per cycle while m_axis does not stall. A stalled
//   m_axis holds the result; the input register keeps taking a beat as long
//   as the result register can drain into the output.
//   Reset clears both valid flags and the pending request.
// ---------------------------------------------------------------------------
module cpu6502_address_mode_unit
    import cau_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // opcode[7:0], pc[23:8], reg_x[31:24], reg_y[39:32], operand_lo[47:40],
    // operand_hi[55:48], pointer_lo[63:56], pointer_hi[71:64]
    input  logic [InDataW-1:0]  s_axis_tdata,
    // action[0]
    input  logic                s_axis_tuser,
    // Result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // mode[3:0], eff_addr[19:4], next_pc[35:20], read_addr_lo[51:36],
    // read_addr_hi[67:52], zero fill[71:68]
    output logic [OutDataW-1:0] m_axis_tdata,
    // kind[1:0]
    output logic [KindW-1:0]    m_axis_tuser
);

    localparam int FillW = OutDataW - ModeW - 4 * AddrW;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t exec_res;
    logic    out_free;
    logic    advance;

    // Pipeline handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // Input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Unpack and hold the input beat
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg.action     <= s_axis_tuser;
            in_item_reg.opcode     <= s_axis_tdata[7:0];
            in_item_reg.pc         <= s_axis_tdata[23:8];
            in_item_reg.reg_x      <= s_axis_tdata[31:24];
            in_item_reg.reg_y      <= s_axis_tdata[39:32];
            in_item_reg.operand_lo <= s_axis_tdata[47:40];
            in_item_reg.operand_hi <= s_axis_tdata[55:48];
            in_item_reg.pointer_lo <= s_axis_tdata[63:56];
            in_item_reg.pointer_hi <= s_axis_tdata[71:64];
        end
    end

    cau_exec u_exec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .res     (exec_res)
    );

    // Result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Capture the result beat
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= exec_res;
        end
    end

    // Pack the result beat
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tdata  = {{FillW{1'b0}},
                            out_res_reg.read_addr_hi,
                            out_res_reg.read_addr_lo,
                            out_res_reg.next_pc,
                            out_res_reg.eff_addr,
                            out_res_reg.mode};

endmodule
